// ----- rtl/bmm_pkg.sv -----
// Shared types, constants and helpers of the Barrett modular multiplier.
package bmm_pkg;

    localparam int unsigned OPERAND_W = 64;
    localparam int unsigned MODULUS_W = 62;
    localparam int unsigned SHIFT_W   = 6;
    localparam int unsigned RANGE_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BARRETT_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RANGE    = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_BELOW_Q  = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_BELOW_2Q = 2'd1;

    localparam logic [MODULUS_W-1:0] MODULUS_RST = 62'd4;
    localparam logic [OPERAND_W-1:0] BARRETT_RST = 64'h8000_0000_0000_0000;
    localparam logic [RANGE_W-1:0]   RANGE_RST   = RANGE_BELOW_Q;
    localparam logic [SHIFT_W-1:0]   SHIFT_RST   = 6'd1;

    typedef struct packed {
        logic [MODULUS_W-1:0] modulus;
        logic [MODULUS_W:0]   modulus_x2;
        logic [RANGE_W-1:0]   range_code;
    } t_bmm_cfg;

    // Number of significant bits of v, zero for zero.
    function automatic logic [SHIFT_W-1:0] bit_width(input logic [MODULUS_W-1:0] v);
        logic [SHIFT_W-1:0] w;
        w = '0;
        for (int j = 0; j < MODULUS_W; j++) begin
            if (v[j] && ((v >> (j + 1)) == '0)) begin
                w = w | SHIFT_W'(j + 1);
            end
        end
        return w;
    endfunction

endpackage

// ----- rtl/bmm_operand_reduce.sv -----
// Two-stage conditional subtraction of both operands into the modulus range.
module bmm_operand_reduce (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bmm_pkg::t_bmm_cfg              i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bmm_pkg::OPERAND_W-1:0]  i_a,
    input  logic [bmm_pkg::OPERAND_W-1:0]  i_b,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bmm_pkg::OPERAND_W-1:0]  o_a,
    output logic [bmm_pkg::OPERAND_W-1:0]  o_b,
    output logic                           o_last
);

    logic                          r_v1, r_v2;
    logic [bmm_pkg::OPERAND_W-1:0] r_a1, r_b1, r_a2, r_b2;
    logic                          r_last1, r_last2;
    logic [bmm_pkg::OPERAND_W-1:0] n_a1, n_b1, n_a2, n_b2;
    logic [bmm_pkg::OPERAND_W-1:0] q_ext, q2_ext;
    logic                          bound4, bound2;
    logic                          en1, en2;

    assign q_ext  = {2'b00, i_cfg.modulus};
    assign q2_ext = {1'b0, i_cfg.modulus_x2};
    assign bound4 = (i_cfg.range_code != bmm_pkg::RANGE_BELOW_Q) &&
                    (i_cfg.range_code != bmm_pkg::RANGE_BELOW_2Q);
    assign bound2 = (i_cfg.range_code != bmm_pkg::RANGE_BELOW_Q);

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        n_a1 = (bound4 && (i_a >= q2_ext)) ? i_a - q2_ext : i_a;
        n_b1 = (bound4 && (i_b >= q2_ext)) ? i_b - q2_ext : i_b;
        n_a2 = (bound2 && (r_a1 >= q_ext)) ? r_a1 - q_ext : r_a1;
        n_b2 = (bound2 && (r_b1 >= q_ext)) ? r_b1 - q_ext : r_b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_a1    <= n_a1;
            r_b1    <= n_b1;
            r_last1 <= i_last;
        end
        if (en2) begin
            r_a2    <= n_a2;
            r_b2    <= n_b2;
            r_last2 <= r_last1;
        end
    end

    assign o_valid = r_v2;
    assign o_a     = r_a2;
    assign o_b     = r_b2;
    assign o_last  = r_last2;

endmodule

// ----- rtl/bmm_mul_wide.sv -----
// Two-stage 64x64 to 128-bit multiplier: registered 32x32 partials, then the sum.
module bmm_mul_wide #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bmm_pkg::OPERAND_W-1:0]   i_a,
    input  logic [bmm_pkg::OPERAND_W-1:0]   i_b,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2*bmm_pkg::OPERAND_W-1:0] o_prod,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int unsigned HALF_W = bmm_pkg::OPERAND_W / 2;
    localparam int unsigned PROD_W = 2 * bmm_pkg::OPERAND_W;

    logic                          r_v1, r_v2;
    logic [bmm_pkg::OPERAND_W-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [SIDE_W-1:0]             r_side1, r_side2;
    logic [PROD_W-1:0]             r_prod;
    logic [bmm_pkg::OPERAND_W-1:0] n_p00, n_p01, n_p10, n_p11;
    logic [PROD_W-1:0]             n_prod;
    logic [HALF_W-1:0]             a_lo, a_hi, b_lo, b_hi;
    logic                          en1, en2;

    assign a_lo = i_a[HALF_W-1:0];
    assign a_hi = i_a[bmm_pkg::OPERAND_W-1:HALF_W];
    assign b_lo = i_b[HALF_W-1:0];
    assign b_hi = i_b[bmm_pkg::OPERAND_W-1:HALF_W];

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        n_p00  = a_lo * b_lo;
        n_p01  = a_lo * b_hi;
        n_p10  = a_hi * b_lo;
        n_p11  = a_hi * b_hi;
        n_prod = {{bmm_pkg::OPERAND_W{1'b0}}, r_p00}
               + {{HALF_W{1'b0}}, r_p01, {HALF_W{1'b0}}}
               + {{HALF_W{1'b0}}, r_p10, {HALF_W{1'b0}}}
               + {r_p11, {bmm_pkg::OPERAND_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p00   <= n_p00;
            r_p01   <= n_p01;
            r_p10   <= n_p10;
            r_p11   <= n_p11;
            r_side1 <= i_side;
        end
        if (en2) begin
            r_prod  <= n_prod;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_side  = r_side2;

endmodule

// ----- rtl/barrett_modular_multiplier_unit.sv -----
// Top level of the pipelined 64-bit Barrett modular multiplier.
//
// Input channel: i_in_valid / o_in_ready carry a request of two 64-bit operands and a
// last-element mark. Output channel: o_out_valid / i_out_ready carry a*b mod q (62 bits)
// and the copied mark. Configuration channel: i_cfg_valid / o_cfg_ready write register
// i_cfg_index (0 modulus, 1 Barrett factor, 2 input range code) with i_cfg_data; it is
// always ready; the user must write it only while the pipeline is empty (unenforced).
//
// Throughput is one request per cycle while the receiver does not stall. The pipeline
// has 12 register stages: two operand-reduction stages, three multipliers of two stages
// each (32x32 partial products, then the 128-bit sum), a shift stage, a residual subtract
// stage and two final correction stages.
//
// Reset clears all stage valid bits and loads modulus 4, factor 2^63 and range code 0.
// When the receiver stalls, each stage holds its request and bubbles close up; input
// is refused only once every stage holds a request.
module barrett_modular_multiplier_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmm_pkg::OPERAND_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bmm_pkg::OPERAND_W-1:0]  i_operand_a,
    input  logic [bmm_pkg::OPERAND_W-1:0]  i_operand_b,
    input  logic                           i_is_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bmm_pkg::MODULUS_W-1:0]  o_product_mod,
    output logic                           o_is_last_out
);

    localparam int unsigned W      = bmm_pkg::OPERAND_W;
    localparam int unsigned QW     = bmm_pkg::MODULUS_W;
    localparam int unsigned SIDE_W = W + 1;

    logic [QW-1:0]                  r_modulus;
    logic [W-1:0]                   r_barrett;
    logic [bmm_pkg::RANGE_W-1:0]    r_range;
    logic [bmm_pkg::SHIFT_W-1:0]    r_shift;
    bmm_pkg::t_bmm_cfg              cfg;
    logic [W-1:0]                   q_ext, q2_ext;
    logic                           q_small;

    logic                           red_ready, red_valid, red_last;
    logic [W-1:0]                   red_a, red_b;
    logic                           m1_ready, m1_valid, m1_last;
    logic [2*W-1:0]                 m1_prod;
    logic                           m2_ready, m2_valid;
    logic [2*W-1:0]                 m2_prod;
    logic [SIDE_W-1:0]              m2_side;
    logic                           m3_ready, m3_valid;
    logic [2*W-1:0]                 m3_prod;
    logic [SIDE_W-1:0]              m3_side;

    logic                           r_v_sh, r_v_z, r_v_s1, r_v_out;
    logic [W-1:0]                   r_c1, r_plo, r_z, r_z1;
    logic                           r_last_sh, r_last_z, r_last_s1, r_last_out;
    logic [QW-1:0]                  r_res;
    logic [2*W-1:0]                 shifted;
    logic [W-1:0]                   n_z, n_z1, n_z2;
    logic [QW-1:0]                  n_res;
    logic                           en_sh, en_z, en_s1, en_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= bmm_pkg::MODULUS_RST;
            r_barrett <= bmm_pkg::BARRETT_RST;
            r_range   <= bmm_pkg::RANGE_RST;
            r_shift   <= bmm_pkg::SHIFT_RST;
        end else begin
            r_shift <= bmm_pkg::bit_width(r_modulus) - bmm_pkg::SHIFT_W'(2);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bmm_pkg::CFG_MODULUS:        r_modulus <= i_cfg_data[QW-1:0];
                    bmm_pkg::CFG_BARRETT_FACTOR: r_barrett <= i_cfg_data;
                    bmm_pkg::CFG_INPUT_RANGE:    r_range   <= i_cfg_data[bmm_pkg::RANGE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg.modulus    = r_modulus;
    assign cfg.modulus_x2 = {r_modulus, 1'b0};
    assign cfg.range_code = r_range;
    assign q_ext          = {2'b00, r_modulus};
    assign q2_ext         = {1'b0, r_modulus, 1'b0};
    assign q_small        = (r_modulus[QW-1:1] == '0);

    // stall chain, back to front
    assign en_out = !r_v_out || i_out_ready;
    assign en_s1  = !r_v_s1 || en_out;
    assign en_z   = !r_v_z || en_s1;
    assign en_sh  = !r_v_sh || m2_ready;

    bmm_operand_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .o_ready (red_ready),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .i_last  (i_is_last),
        .o_valid (red_valid),
        .i_ready (m1_ready),
        .o_a     (red_a),
        .o_b     (red_b),
        .o_last  (red_last)
    );

    assign o_in_ready = red_ready;

    bmm_mul_wide #(.SIDE_W(1)) u_mul_ab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (red_valid),
        .o_ready (m1_ready),
        .i_a     (red_a),
        .i_b     (red_b),
        .i_side  (red_last),
        .o_valid (m1_valid),
        .i_ready (en_sh),
        .o_prod  (m1_prod),
        .o_side  (m1_last)
    );

    // product >> (bitwidth(q) - 2), low word
    assign shifted = m1_prod >> r_shift;

    always_ff @(posedge i_clk) begin
        if (en_sh) begin
            r_c1      <= shifted[W-1:0];
            r_plo     <= m1_prod[W-1:0];
            r_last_sh <= m1_last;
        end
    end

    bmm_mul_wide #(.SIDE_W(SIDE_W)) u_mul_est (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_sh),
        .o_ready (m2_ready),
        .i_a     (r_c1),
        .i_b     (r_barrett),
        .i_side  ({r_plo, r_last_sh}),
        .o_valid (m2_valid),
        .i_ready (m3_ready),
        .o_prod  (m2_prod),
        .o_side  (m2_side)
    );

    bmm_mul_wide #(.SIDE_W(SIDE_W)) u_mul_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m2_valid),
        .o_ready (m3_ready),
        .i_a     (m2_prod[2*W-1:W]),
        .i_b     (q_ext),
        .i_side  (m2_side),
        .o_valid (m3_valid),
        .i_ready (en_z),
        .o_prod  (m3_prod),
        .o_side  (m3_side)
    );

    always_comb begin
        n_z   = m3_side[SIDE_W-1:1] - m3_prod[W-1:0];
        n_z1  = (r_z >= q2_ext) ? r_z - q2_ext : r_z;
        n_z2  = (r_z1 >= q_ext) ? r_z1 - q_ext : r_z1;
        n_res = q_small ? '0 : n_z2[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en_z) begin
            r_z      <= n_z;
            r_last_z <= m3_side[0];
        end
        if (en_s1) begin
            r_z1      <= n_z1;
            r_last_s1 <= r_last_z;
        end
        if (en_out) begin
            r_res      <= n_res;
            r_last_out <= r_last_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sh  <= 1'b0;
            r_v_z   <= 1'b0;
            r_v_s1  <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (en_sh)  r_v_sh  <= m1_valid;
            if (en_z)   r_v_z   <= m3_valid;
            if (en_s1)  r_v_s1  <= r_v_z;
            if (en_out) r_v_out <= r_v_s1;
        end
    end

    assign o_out_valid   = r_v_out;
    assign o_product_mod = r_res;
    assign o_is_last_out = r_last_out;

`ifndef SYNTH
    a_refuse_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && r_v_s1 && r_v_z))
        else $error("input refused while the tail of the pipeline has a bubble");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_out_valid && !r_v_sh && !r_v_z))
        else $error("stage valid set right after reset");

    a_stalled_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_s1 && !en_s1) |=> (r_v_s1 && $stable(r_z1) && $stable(r_last_s1)))
        else $error("stalled correction stage lost or changed its request");
`endif

endmodule

// ----- sim/barrett_modular_multiplier_unit_tb.sv -----
// Self-checking testbench of the pipelined 64-bit Barrett modular multiplier.
`timescale 1ns / 1ps

module barrett_modular_multiplier_unit_tb;

    localparam int unsigned W  = bmm_pkg::OPERAND_W;
    localparam int unsigned QW = bmm_pkg::MODULUS_W;

    localparam logic [bmm_pkg::CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [bmm_pkg::RANGE_W-1:0]   RANGE_BELOW_4Q = 2'd2;
    localparam logic [bmm_pkg::RANGE_W-1:0]   RANGE_ALIAS_4Q = 2'd3;
    localparam logic [W-1:0]                  MODULUS_MAX    = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 24;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_BURSTY} t_ready_mode;

    typedef struct packed {
        logic [QW-1:0] product;
        logic          last;
    } t_product;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [bmm_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [W-1:0]                    i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    logic [W-1:0]                    i_operand_a = '0;
    logic [W-1:0]                    i_operand_b = '0;
    logic                            i_is_last   = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [QW-1:0]                   o_product_mod;
    logic                            o_is_last_out;

    // predictor copy of the register file
    logic [QW-1:0]                   cfg_modulus = bmm_pkg::MODULUS_RST;
    logic [W-1:0]                    cfg_factor  = bmm_pkg::BARRETT_RST;
    logic [bmm_pkg::RANGE_W-1:0]     cfg_range   = bmm_pkg::RANGE_RST;

    t_product    pending_products[$];
    int          errors      = 0;
    int          idle_cycles = 0;
    int          gap_max     = 0;
    int          burst_max   = 0;
    int          burst_left  = 0;
    t_ready_mode ready_mode  = READY_ALWAYS;
    int          stall_count = 0;
    int          stall_left  = 0;

    barrett_modular_multiplier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_is_last     (i_is_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_product_mod (o_product_mod),
        .o_is_last_out (o_is_last_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int modulus_bits(input logic [W-1:0] q);
        int w;
        w = 0;
        for (int j = 0; j < QW; j++) begin
            if (q[j]) begin
                w = j + 1;
            end
        end
        return w;
    endfunction

    function automatic logic [W-1:0] ideal_factor(input logic [W-1:0] q);
        logic [127:0] quot;
        if (q < 2) begin
            return rand64();
        end
        quot = (128'd1 << (modulus_bits(q) + 62)) / {64'd0, q};
        return quot[W-1:0];
    endfunction

    function automatic logic [W-1:0] rand_modulus();
        int w;
        logic [W-1:0] m;
        w = $urandom_range(2, QW);
        m = rand64() & ((64'd1 << w) - 64'd1);
        return m | (64'd1 << (w - 1));
    endfunction

    // conditional subtraction, 64-bit wraparound
    function automatic logic [W-1:0] bring_into_range(input logic [W-1:0] v,
                                                       input logic [W-1:0] q,
                                                       input int bound);
        logic [W-1:0] r;
        r = v;
        if (bound >= 4 && r >= (q << 1)) begin
            r = r - (q << 1);
        end
        if (bound >= 2 && r >= q) begin
            r = r - q;
        end
        return r;
    endfunction

    function automatic logic [QW-1:0] barrett_product(input logic [W-1:0] a,
                                                      input logic [W-1:0] b);
        logic [W-1:0] q, x, y, c1, z;
        logic [127:0] p, e;
        int bound;
        q = {2'b00, cfg_modulus};
        if (q < 2) begin
            return '0;
        end
        if (cfg_range == bmm_pkg::RANGE_BELOW_Q) begin
            bound = 1;
        end else if (cfg_range == bmm_pkg::RANGE_BELOW_2Q) begin
            bound = 2;
        end else begin
            bound = 4;
        end
        x = bring_into_range(a, q, bound);
        y = bring_into_range(b, q, bound);
        p = {64'd0, x} * {64'd0, y};
        c1 = 64'(p >> (modulus_bits(q) - 2));
        e = {64'd0, c1} * {64'd0, cfg_factor};
        z = p[63:0] - e[127:64] * q;
        z = bring_into_range(z, q, 4);
        return z[QW-1:0];
    endfunction

    function automatic logic [W-1:0] pick_operand(input logic [W-1:0] limit);
        int sel;
        sel = $urandom_range(0, 15);
        if (limit == 0 || sel == 0) begin
            return rand64();
        end
        if (sel == 1) begin
            return limit - 64'd1;
        end
        if (sel == 2) begin
            return '0;
        end
        return rand64() % limit;
    endfunction

    task automatic write_reg(input logic [bmm_pkg::CFG_IDX_W-1:0] index,
                             input logic [W-1:0] data);
        i_cfg_index <= index;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) begin
            @(posedge i_clk);
        end
        case (index)
            bmm_pkg::CFG_MODULUS:        cfg_modulus = data[QW-1:0];
            bmm_pkg::CFG_BARRETT_FACTOR: cfg_factor  = data;
            bmm_pkg::CFG_INPUT_RANGE:    cfg_range   = data[bmm_pkg::RANGE_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [W-1:0] q_data,
                              input logic [W-1:0] factor,
                              input logic [bmm_pkg::RANGE_W-1:0] range_code);
        write_reg(bmm_pkg::CFG_MODULUS, q_data);
        write_reg(bmm_pkg::CFG_BARRETT_FACTOR, factor);
        write_reg(bmm_pkg::CFG_INPUT_RANGE, {62'd0, range_code});
    endtask

    task automatic send_item(input logic [W-1:0] a, input logic [W-1:0] b,
                             input logic last);
        t_product exp_item;
        int gap;
        i_operand_a <= a;
        i_operand_b <= b;
        i_is_last   <= last;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready)) begin
            @(posedge i_clk);
        end
        exp_item.product = barrett_product(a, b);
        exp_item.last    = last;
        pending_products.push_back(exp_item);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(0, burst_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop sending and wait for every outstanding request to return
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_products.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_reset_config();
        send_item(64'd0, 64'd0, 1'b0);
        send_item(64'd3, 64'd3, 1'b1);
        send_item(64'd1, 64'd2, 1'b0);
        send_item(64'd3, 64'd2, 1'b1);
        drain();
    endtask

    // bitwidth-two moduli take the unshifted low product word
    task automatic test_shift_zero();
        set_config(64'd2, ideal_factor(64'd2), bmm_pkg::RANGE_BELOW_2Q);
        send_item(64'd3, 64'd1, 1'b1);
        send_item(64'd2, 64'd3, 1'b0);
        drain();
        set_config(64'd3, ideal_factor(64'd3), RANGE_BELOW_4Q);
        send_item(64'd11, 64'd11, 1'b0);
        send_item(64'd5, 64'd7, 1'b1);
        drain();
    endtask

    task automatic test_wide_modulus();
        logic [W-1:0] q;
        q = MODULUS_MAX;
        set_config(q, ideal_factor(q), RANGE_BELOW_4Q);
        send_item((q << 2) - 64'd1, (q << 2) - 64'd1, 1'b1);
        send_item(q - 64'd1, q - 64'd1, 1'b0);
        send_item(q << 1, q, 1'b1);
        send_item(64'd0, (q << 2) - 64'd1, 1'b0);
        drain();
        write_reg(bmm_pkg::CFG_INPUT_RANGE, {62'd0, RANGE_ALIAS_4Q});
        send_item((q << 2) - 64'd1, (q << 1) - 64'd1, 1'b1);
        drain();
        q = 64'd1 << 61;
        set_config(q, ideal_factor(q), bmm_pkg::RANGE_BELOW_2Q);
        send_item((q << 1) - 64'd1, (q << 1) - 64'd1, 1'b0);
        drain();
    endtask

    task automatic test_degenerate_config();
        set_config(64'd0, rand64(), RANGE_BELOW_4Q);
        send_item('1, '1, 1'b1);
        drain();
        write_reg(bmm_pkg::CFG_MODULUS, 64'd1);
        send_item(64'd5, 64'd7, 1'b0);
        drain();
        // bits above the modulus field are dropped
        set_config(64'hC000_0000_0000_0007, ideal_factor(64'd7), bmm_pkg::RANGE_BELOW_Q);
        send_item(64'd6, 64'd6, 1'b1);
        drain();
        set_config(64'd1000003, '1, bmm_pkg::RANGE_BELOW_Q);
        send_item(64'd1000002, 64'd1000002, 1'b0);
        drain();
        write_reg(bmm_pkg::CFG_BARRETT_FACTOR, 64'd0);
        send_item(64'd999, 64'd999, 1'b1);
        drain();
        set_config(64'd12345, ideal_factor(64'd12345), bmm_pkg::RANGE_BELOW_Q);
        send_item('1, 64'hAAAA_5555_0F0F_F0F0, 1'b0);
        drain();
        write_reg(CFG_UNUSED, rand64());
        send_item(64'd12344, 64'd12344, 1'b1);
        drain();
    endtask

    task automatic test_random_phases();
        int sent, count, kind;
        logic [W-1:0] q, limit, data;
        logic [bmm_pkg::RANGE_W-1:0] range_code;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 19);
            case (kind)
                0:       q = 64'($urandom_range(0, 1));
                1:       q = 64'($urandom_range(2, 3));
                2:       q = MODULUS_MAX;
                default: q = rand_modulus();
            endcase
            range_code = bmm_pkg::RANGE_W'($urandom_range(0, 3));
            data = rand64();
            data[QW-1:0] = q[QW-1:0];
            write_reg(bmm_pkg::CFG_MODULUS, data);
            write_reg(bmm_pkg::CFG_BARRETT_FACTOR, (kind == 3) ? rand64() : ideal_factor(q));
            data = rand64();
            data[bmm_pkg::RANGE_W-1:0] = range_code;
            write_reg(bmm_pkg::CFG_INPUT_RANGE, data);
            if (range_code == bmm_pkg::RANGE_BELOW_Q) begin
                limit = q;
            end else if (range_code == bmm_pkg::RANGE_BELOW_2Q) begin
                limit = q << 1;
            end else begin
                limit = q << 2;
            end
            if (sent == 0) begin
                gap_max = 0;
                burst_max = 0;
                ready_mode = READY_ALWAYS;
            end else begin
                gap_max = $urandom_range(0, 12);
                burst_max = $urandom_range(0, 20);
                ready_mode = t_ready_mode'($urandom_range(0, 3));
            end
            burst_left = 0;
            count = $urandom_range(60, 240);
            if (count > RANDOM_ITEMS - sent) begin
                count = RANDOM_ITEMS - sent;
            end
            repeat (count) begin
                send_item(pick_operand(limit), pick_operand(limit), 1'($urandom_range(0, 1)));
                sent++;
            end
            drain();
        end
    endtask

    always @(posedge i_clk) begin
        stall_count <= stall_count + 1;
        case (ready_mode)
            READY_ALWAYS:   i_out_ready <= 1'b1;
            READY_RANDOM:   i_out_ready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: i_out_ready <= ((stall_count % 9) > 3);
            default: begin
                if (stall_left > 0) begin
                    stall_left  <= stall_left - 1;
                    i_out_ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left  <= $urandom_range(5, 30);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_product exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_products.size() == 0) begin
                $display("%0t unexpected result: product %h last %b",
                         $realtime, o_product_mod, o_is_last_out);
                errors++;
            end else begin
                exp_item = pending_products.pop_front();
                if (o_product_mod !== exp_item.product) begin
                    $display("%0t product mismatch: expected %h actual %h",
                             $realtime, exp_item.product, o_product_mod);
                    errors++;
                end
                if (o_is_last_out !== exp_item.last) begin
                    $display("%0t last mark mismatch: expected %b actual %b",
                             $realtime, exp_item.last, o_is_last_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no request moved for %0d cycles", $realtime, idle_cycles);
            $display("barrett_modular_multiplier_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_max = 3;
        burst_max = 4;
        ready_mode = READY_RANDOM;
        test_reset_config();
        test_shift_zero();
        test_wide_modulus();
        test_degenerate_config();
        test_random_phases();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_products.size() != 0) begin
            $display("%0t %0d results never arrived", $realtime, pending_products.size());
            errors++;
        end
        if (errors == 0) begin
            $display("barrett_modular_multiplier_unit verification clean");
        end else begin
            $display("barrett_modular_multiplier_unit verification failed");
        end
        $finish;
    end

endmodule
